@@ rtl/cwc_pkg.sv @@
// Shared types and constants for the circle against wall collision check.
package cwc_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam int IDX_BITS = 6;
  localparam int CNT_BITS = 7;
  localparam int RAD_BITS = 8;
  localparam int R2_BITS  = 2 * RAD_BITS;

  typedef struct packed {
    logic vld;
    logic last;
  } tag_t;

  typedef struct packed {
    logic vld;
    logic last;
    logic touch;
  } res_t;

endpackage

@@ rtl/circle_wall_collision_check_top.sv @@
// Top level of the circle against wall segment collision check.
//
// A write item (tuser 0) stores one wall segment in table slot wall_index;
// slots at or above MAX_WALLS are dropped and writes give no result. A query item
// (tuser 1) tests its circle against slots 0 .. N-1, N = min(wall_count, MAX_WALLS), and
// returns one item whose bit 0 is the hit flag. After the query is accepted the wall
// table, which has one read port, feeds one wall per cycle into the five-stage test
// pipeline, and the hit flag gathers the pipeline results; the block takes no new item
// until the result is in the output register. A query with N zero goes straight to the
// done state and offers no hit. An earlier result not yet taken holds the finished
// flag back until the output register frees. Slots a query reads must have been written
// since reset. A finished result waits in the output register while the block takes
// further items.
module circle_wall_collision_check_top #(
  parameter int  MAX_WALLS  = 64,
  parameter int  COORD_BITS = 12,
  localparam int IN_W       = ((cwc_pkg::IDX_BITS + 6 * COORD_BITS + cwc_pkg::RAD_BITS + 7)
                               / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [cwc_pkg::CNT_BITS-1:0]  cfg_wr_data,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // wall_index, start_x, start_y, end_x, end_y, centre_x, centre_y, circle_radius
  input  logic [IN_W-1:0]               in_tdata,
  // cmd
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // hit
  output logic [7:0]                    out_tdata
);

  localparam int C      = COORD_BITS;
  localparam int AW     = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
  localparam int CNTW   = ($clog2(MAX_WALLS + 1) > cwc_pkg::CNT_BITS) ?
                          $clog2(MAX_WALLS + 1) : cwc_pkg::CNT_BITS;
  localparam int O_IDX  = 0;
  localparam int O_SX   = cwc_pkg::IDX_BITS;
  localparam int O_CX   = O_SX + 4 * C;
  localparam int O_CY   = O_CX + C;
  localparam int O_R    = O_CY + C;

  cwc_pkg::state_t state_r, state_nxt;

  logic [cwc_pkg::CNT_BITS-1:0] wall_count_r;
  logic [CNTW-1:0]              cnt_eff, idx_r, idx_nxt;
  logic                         hit_acc_r, hit_nxt;
  logic                         out_tvalid_r, out_vld_nxt, out_hit_r, out_hit_nxt;
  logic signed [C-1:0]          cx_r, cy_r;
  logic [cwc_pkg::R2_BITS-1:0]  r2_r;
  logic                         q_ld, mem_we, idx_ok, in_acc;
  logic [cwc_pkg::IDX_BITS-1:0] wr_idx;
  logic [cwc_pkg::RAD_BITS-1:0] radius;
  logic [4*C-1:0]               rd_wall;
  cwc_pkg::tag_t                tag_issue;
  cwc_pkg::res_t                res;

  assign wr_idx  = in_tdata[O_IDX +: cwc_pkg::IDX_BITS];
  assign radius  = in_tdata[O_R +: cwc_pkg::RAD_BITS];
  assign idx_ok  = 32'(wr_idx) < MAX_WALLS;
  assign cnt_eff = (CNTW'(wall_count_r) > CNTW'(MAX_WALLS)) ? CNTW'(MAX_WALLS)
                                                              : CNTW'(wall_count_r);
  assign in_acc  = in_tvalid && in_tready;

  cwc_wall_mem #(
    .DEPTH (MAX_WALLS),
    .AW    (AW),
    .DW    (4 * C)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(wr_idx)),
    .wdata (in_tdata[O_SX +: 4 * C]),
    .raddr (idx_nxt[AW-1:0]),
    .rdata (rd_wall)
  );

  cwc_seg_test #(
    .COORD_BITS (C)
  ) u_test (
    .clk    (clk),
    .rst_n  (rst_n),
    .tag_i  (tag_issue),
    .wall_i (rd_wall),
    .cx_i   (cx_r),
    .cy_i   (cy_r),
    .r2_i   (r2_r),
    .res_o  (res)
  );

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    hit_nxt     = hit_acc_r;
    out_vld_nxt = out_tvalid_r && !out_tready;
    out_hit_nxt = out_hit_r;
    q_ld        = 1'b0;
    mem_we      = 1'b0;
    tag_issue   = '0;
    in_tready   = 1'b0;
    if (res.vld) begin
      hit_nxt = hit_acc_r | res.touch;
    end
    case (state_r)
      cwc_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser == cwc_pkg::CMD_QUERY) begin
            q_ld      = 1'b1;
            hit_nxt   = 1'b0;
            idx_nxt   = '0;
            state_nxt = (cnt_eff == '0) ? cwc_pkg::ST_DONE : cwc_pkg::ST_SCAN;
          end else begin
            mem_we = idx_ok;
          end
        end
      end
      cwc_pkg::ST_SCAN: begin
        tag_issue.vld  = 1'b1;
        tag_issue.last = idx_r == CNTW'(cnt_eff - CNTW'(1));
        idx_nxt        = CNTW'(idx_r + CNTW'(1));
        if (tag_issue.last) begin
          state_nxt = cwc_pkg::ST_DRAIN;
        end
      end
      cwc_pkg::ST_DRAIN: begin
        if (res.vld && res.last) begin
          state_nxt = cwc_pkg::ST_DONE;
        end
      end
      cwc_pkg::ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_vld_nxt = 1'b1;
          out_hit_nxt = hit_acc_r;
          state_nxt   = cwc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cwc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= cwc_pkg::ST_IDLE;
      wall_count_r <= '0;
      idx_r        <= '0;
      hit_acc_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      hit_acc_r    <= hit_nxt;
      out_tvalid_r <= out_vld_nxt;
      if (cfg_wr_en) begin
        wall_count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r <= out_hit_nxt;
    if (q_ld) begin
      cx_r <= $signed(in_tdata[O_CX +: C]);
      cy_r <= $signed(in_tdata[O_CY +: C]);
      r2_r <= cwc_pkg::R2_BITS'(radius) * cwc_pkg::R2_BITS'(radius);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'b0, out_hit_r};

`ifndef SYNTH
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == cwc_pkg::ST_DONE))
    else $error("result raised outside the done state");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == cwc_pkg::ST_SCAN |-> idx_r < cnt_eff)
    else $error("scan index beyond wall count");

  a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser == cwc_pkg::CMD_QUERY && cnt_eff == '0
      |=> state_r == cwc_pkg::ST_DONE && !hit_acc_r)
    else $error("empty query did not finish with no hit");

  a_res_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld |-> state_r == cwc_pkg::ST_SCAN || state_r == cwc_pkg::ST_DRAIN)
    else $error("pipeline result outside a query");
`endif

endmodule

@@ rtl/cwc_wall_mem.sv @@
// Wall segment table: one write port, one registered read port.
module cwc_wall_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 48
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/cwc_seg_test.sv @@
// Pipelined exact integer test of one circle against one wall segment per cycle.
module cwc_seg_test #(
  parameter int COORD_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cwc_pkg::tag_t                    tag_i,
  input  logic [4*COORD_BITS-1:0]          wall_i,
  input  logic signed [COORD_BITS-1:0]     cx_i,
  input  logic signed [COORD_BITS-1:0]     cy_i,
  input  logic [cwc_pkg::R2_BITS-1:0]      r2_i,
  output cwc_pkg::res_t                    res_o
);

  localparam int C   = COORD_BITS;
  localparam int DW  = C + 1;
  localparam int PW  = 2 * DW;
  localparam int SW  = PW + 1;
  localparam int AB  = (SW < 32) ? SW : 32;
  localparam int LW  = (SW > 33) ? SW : 33;
  localparam int RNW = cwc_pkg::R2_BITS + SW;
  localparam int CW  = (2 * AB > RNW) ? 2 * AB : RNW;

  cwc_pkg::tag_t tag1_r, tag2_r, tag3_r, tag4_r;
  cwc_pkg::res_t res_r, res_nxt;

  logic signed [C-1:0]  ax, ay, bx, by;
  logic signed [DW-1:0] dx_nxt, dy_nxt, wx_nxt, wy_nxt, ex_nxt, ey_nxt;
  logic signed [DW-1:0] dx_r, dy_r, wx_r, wy_r, ex_r, ey_r;

  logic signed [PW-1:0] wdx_r, wdy_r, ddx_r, ddy_r, wxdy_r, wydx_r;
  logic signed [PW-1:0] wwx_r, wwy_r, eex_r, eey_r;

  logic signed [SW-1:0] dot_r, n_r, cr_r, da_r, db_r;

  logic [SW-1:0]        abs_nxt;
  logic                 big_nxt;
  logic [AB-1:0]        a_nxt;
  logic                 sel_a_r, sel_b_r, hit_a_r, hit_b_r, big_r;
  logic [2*AB-1:0]      a2_r;
  logic [RNW-1:0]       r2n_r;

  assign ax = $signed(wall_i[0 +: C]);
  assign ay = $signed(wall_i[C +: C]);
  assign bx = $signed(wall_i[2*C +: C]);
  assign by = $signed(wall_i[3*C +: C]);

  assign dx_nxt = DW'(bx) - DW'(ax);
  assign dy_nxt = DW'(by) - DW'(ay);
  assign wx_nxt = DW'(cx_i) - DW'(ax);
  assign wy_nxt = DW'(cy_i) - DW'(ay);
  assign ex_nxt = DW'(cx_i) - DW'(bx);
  assign ey_nxt = DW'(cy_i) - DW'(by);

  assign abs_nxt = cr_r[SW-1] ? $unsigned(-cr_r) : $unsigned(cr_r);
  assign big_nxt = LW'(abs_nxt) > LW'(33'h0_FFFF_FFFF);
  assign a_nxt   = AB'(abs_nxt);

  always_comb begin
    res_nxt.vld  = tag4_r.vld;
    res_nxt.last = tag4_r.last;
    if (sel_a_r) begin
      res_nxt.touch = hit_a_r;
    end else if (sel_b_r) begin
      res_nxt.touch = hit_b_r;
    end else begin
      res_nxt.touch = !big_r && (CW'(a2_r) <= CW'(r2n_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
      tag4_r <= '0;
      res_r  <= '0;
    end else begin
      tag1_r <= tag_i;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
      tag4_r <= tag3_r;
      res_r  <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dx_r <= dx_nxt;
    dy_r <= dy_nxt;
    wx_r <= wx_nxt;
    wy_r <= wy_nxt;
    ex_r <= ex_nxt;
    ey_r <= ey_nxt;

    wdx_r  <= PW'(wx_r) * PW'(dx_r);
    wdy_r  <= PW'(wy_r) * PW'(dy_r);
    ddx_r  <= PW'(dx_r) * PW'(dx_r);
    ddy_r  <= PW'(dy_r) * PW'(dy_r);
    wxdy_r <= PW'(wx_r) * PW'(dy_r);
    wydx_r <= PW'(wy_r) * PW'(dx_r);
    wwx_r  <= PW'(wx_r) * PW'(wx_r);
    wwy_r  <= PW'(wy_r) * PW'(wy_r);
    eex_r  <= PW'(ex_r) * PW'(ex_r);
    eey_r  <= PW'(ey_r) * PW'(ey_r);

    dot_r <= SW'(wdx_r) + SW'(wdy_r);
    n_r   <= SW'(ddx_r) + SW'(ddy_r);
    cr_r  <= SW'(wxdy_r) - SW'(wydx_r);
    da_r  <= SW'(wwx_r) + SW'(wwy_r);
    db_r  <= SW'(eex_r) + SW'(eey_r);

    sel_a_r <= (n_r == '0) || (dot_r <= SW'(0));
    sel_b_r <= dot_r >= n_r;
    hit_a_r <= $unsigned(da_r) <= SW'(r2_i);
    hit_b_r <= $unsigned(db_r) <= SW'(r2_i);
    big_r   <= big_nxt;
    a2_r    <= (2*AB)'(a_nxt) * (2*AB)'(a_nxt);
    r2n_r   <= RNW'(r2_i) * RNW'($unsigned(n_r));
  end

  assign res_o = res_r;

endmodule

@@ bench/cwc_checker.sv @@
`timescale 1ns / 100ps
// Checker that predicts each collision result from observed items and compares it.
module cwc_checker #(
  parameter int MAX_WALLS  = 64,
  parameter int COORD_BITS = 12,
  parameter int IN_W       = 88
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [cwc_pkg::CNT_BITS-1:0] cfg_wr_data,
  input  logic                         in_tvalid,
  input  logic                         in_tready,
  input  logic [IN_W-1:0]              in_tdata,
  input  logic                         in_tuser,
  input  logic                         out_tvalid,
  input  logic                         out_tready,
  input  logic [7:0]                   out_tdata,
  output int                           fail_count,
  output int                           hits_pending
);

  localparam int PAD_BITS = IN_W - cwc_pkg::IDX_BITS - 6 * COORD_BITS - cwc_pkg::RAD_BITS;

  typedef struct packed {
    logic [PAD_BITS-1:0]           pad;
    logic [cwc_pkg::RAD_BITS-1:0]  radius;
    logic signed [COORD_BITS-1:0]  centre_y;
    logic signed [COORD_BITS-1:0]  centre_x;
    logic signed [COORD_BITS-1:0]  end_y;
    logic signed [COORD_BITS-1:0]  end_x;
    logic signed [COORD_BITS-1:0]  start_y;
    logic signed [COORD_BITS-1:0]  start_x;
    logic [cwc_pkg::IDX_BITS-1:0]  wall_index;
  } item_fields_t;

  typedef struct {
    longint ax;
    longint ay;
    longint bx;
    longint by;
  } wall_seg_t;

  wall_seg_t wall_mem [MAX_WALLS];
  int        wall_limit;
  bit        hit_due [$];

  // Exact integer test of the circle against the first walls_tested segments.
  function automatic bit predict_hit(longint cx, longint cy, longint r2, int walls_tested);
    longint dx, dy, wx, wy, dot, len2, ex, ey, cr;
    for (int i = 0; i < walls_tested; i++) begin
      dx   = wall_mem[i].bx - wall_mem[i].ax;
      dy   = wall_mem[i].by - wall_mem[i].ay;
      wx   = cx - wall_mem[i].ax;
      wy   = cy - wall_mem[i].ay;
      dot  = wx * dx + wy * dy;
      len2 = dx * dx + dy * dy;
      if (len2 == 0 || dot <= 0) begin
        if (wx * wx + wy * wy <= r2) return 1'b1;
      end else if (dot >= len2) begin
        ex = cx - wall_mem[i].bx;
        ey = cy - wall_mem[i].by;
        if (ex * ex + ey * ey <= r2) return 1'b1;
      end else begin
        cr = wx * dy - wy * dx;
        if (cr * cr <= r2 * len2) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin : observe
    item_fields_t f;
    bit           want;
    longint       r;
    if (!rst_n) begin
      hit_due.delete();
      wall_limit = 0;
      fail_count = 0;
    end else begin
      if (cfg_wr_en) wall_limit = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        f = in_tdata;
        if (in_tuser == cwc_pkg::CMD_WRITE) begin
          if (f.wall_index < MAX_WALLS)
            wall_mem[f.wall_index] = '{longint'(f.start_x), longint'(f.start_y),
                                       longint'(f.end_x), longint'(f.end_y)};
        end else begin
          r = longint'(f.radius);
          hit_due.push_back(predict_hit(longint'(f.centre_x), longint'(f.centre_y), r * r,
                                        (wall_limit > MAX_WALLS) ? MAX_WALLS : wall_limit));
        end
      end
      if (out_tvalid && out_tready) begin
        if (hit_due.size() == 0) begin
          $error("hit item with no expectation waiting: actual %0d", out_tdata[0]);
          fail_count++;
        end else begin
          want = hit_due.pop_front();
          if (out_tdata[0] !== want) begin
            $error("hit mismatch: expected %0d, actual %0d", want, out_tdata[0]);
            fail_count++;
          end
        end
      end
    end
    hits_pending = hit_due.size();
  end

endmodule

@@ bench/tb_circle_wall_collision_check_top.sv @@
`timescale 1ns / 100ps
// Testbench top: drives wall writes and circle queries, paces both channels, gives the verdict.
module tb_circle_wall_collision_check_top;

  localparam int MAX_WALLS   = 64;
  localparam int COORD_BITS  = 12;
  localparam int IN_W        = 88;
  localparam int PAD_BITS    = IN_W - cwc_pkg::IDX_BITS - 6 * COORD_BITS - cwc_pkg::RAD_BITS;
  localparam int COORD_MIN   = -(1 << (COORD_BITS - 1));
  localparam int COORD_MAX   = (1 << (COORD_BITS - 1)) - 1;
  localparam int HOLD_OFF    = 80;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 140;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         cfg_wr_en;
  logic [cwc_pkg::CNT_BITS-1:0] cfg_wr_data;
  logic                         in_tvalid;
  logic                         in_tready;
  logic [IN_W-1:0]              in_tdata;
  logic                         in_tuser;
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [7:0]                   out_tdata;

  int fail_count;
  int hits_pending;
  int snd_idle_pct;
  int rcv_idle_pct;
  int wall_count_now;
  int cycle_cnt;
  int wall_sx [MAX_WALLS];
  int wall_sy [MAX_WALLS];
  int wall_ex [MAX_WALLS];
  int wall_ey [MAX_WALLS];

  circle_wall_collision_check_top #(
    .MAX_WALLS  (MAX_WALLS),
    .COORD_BITS (COORD_BITS)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  cwc_checker #(
    .MAX_WALLS  (MAX_WALLS),
    .COORD_BITS (COORD_BITS),
    .IN_W       (IN_W)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .hits_pending (hits_pending)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  function automatic int clamp_coord(int v);
    if (v < COORD_MIN) return COORD_MIN;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(COORD_MAX - COORD_MIN)) + COORD_MIN;
  endfunction

  task automatic push_item(input logic cmd, input int idx, input int sx, input int sy,
                           input int ex, input int ey, input int cx, input int cy,
                           input int r);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{PAD_BITS{1'b0}}, cwc_pkg::RAD_BITS'(r), COORD_BITS'(cy), COORD_BITS'(cx),
                  COORD_BITS'(ey), COORD_BITS'(ex), COORD_BITS'(sy), COORD_BITS'(sx),
                  cwc_pkg::IDX_BITS'(idx)};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic store_wall(input int idx, input int sx, input int sy, input int ex,
                            input int ey);
    wall_sx[idx] = sx;
    wall_sy[idx] = sy;
    wall_ex[idx] = ex;
    wall_ey[idx] = ey;
    push_item(cwc_pkg::CMD_WRITE, idx, sx, sy, ex, ey, rand_coord(), rand_coord(),
              $urandom_range(255));
  endtask

  task automatic probe_circle(input int cx, input int cy, input int r);
    push_item(cwc_pkg::CMD_QUERY, $urandom_range(MAX_WALLS - 1), rand_coord(), rand_coord(),
              rand_coord(), rand_coord(), cx, cy, r);
  endtask

  task automatic random_wall(input int idx);
    int ax, ay, kind;
    kind = $urandom_range(9);
    ax   = rand_coord();
    ay   = rand_coord();
    if (kind < 2)
      store_wall(idx, ax, ay, rand_coord(), rand_coord());
    else if (kind < 4)
      store_wall(idx, ax, ay, ax, ay);
    else
      store_wall(idx, ax, ay, clamp_coord(ax + int'($urandom_range(400)) - 200),
                 clamp_coord(ay + int'($urandom_range(400)) - 200));
  endtask

  // Aim most queries at a point along a tested wall so hits and misses both occur.
  task automatic random_query();
    int n, k, t, px, py, r, sel;
    n = (wall_count_now > MAX_WALLS) ? MAX_WALLS : wall_count_now;
    if (n > 0 && $urandom_range(99) < 65) begin
      k  = $urandom_range(n - 1);
      t  = $urandom_range(16);
      px = wall_sx[k] + (wall_ex[k] - wall_sx[k]) * t / 16;
      py = wall_sy[k] + (wall_ey[k] - wall_sy[k]) * t / 16;
      px = clamp_coord(px + int'($urandom_range(600)) - 300);
      py = clamp_coord(py + int'($urandom_range(600)) - 300);
    end else begin
      px = rand_coord();
      py = rand_coord();
    end
    sel = $urandom_range(9);
    r   = (sel == 0) ? 0 : (sel == 1) ? 255 : int'($urandom_range(255));
    probe_circle(px, py, r);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (hits_pending != 0) @(negedge clk);
  endtask

  // Change the count only once the block is idle.
  task automatic set_wall_count(input int value);
    drain_results();
    repeat (HOLD_OFF) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cwc_pkg::CNT_BITS'(value);
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    wall_count_now = value;
  endtask

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("circle_wall_collision_check_top test failed");
    $finish;
  end

  initial begin : stimulus
    int plan [PHASES];
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = cwc_pkg::CMD_WRITE;
    snd_idle_pct   = 38;
    rcv_idle_pct   = 49;
    wall_count_now = 0;
    plan           = '{1, 64, 127, 0, 2, 65, 33, 100, 64, 1, 0, 17};
    plan[10]       = $urandom_range(127);
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    probe_circle(0, 0, 255);
    probe_circle(COORD_MIN, COORD_MAX, 0);
    store_wall(0, 0, 0, 100, 0);
    store_wall(1, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
    store_wall(2, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
    set_wall_count(3);
    probe_circle(-30, 0, 29);
    probe_circle(-30, 0, 30);
    probe_circle(130, 40, 50);
    probe_circle(130, 40, 49);
    probe_circle(50, -20, 20);
    probe_circle(50, -20, 19);
    probe_circle(COORD_MAX, COORD_MIN, 0);
    probe_circle(COORD_MAX - 1, COORD_MIN, 0);
    probe_circle(0, COORD_MAX - 255, 255);
    probe_circle(COORD_MIN, COORD_MIN, 255);

    for (int i = 3; i < MAX_WALLS; i++) random_wall(i);

    for (int p = 0; p < PHASES; p++) begin
      if (p == 4) begin
        snd_idle_pct = 49;
        rcv_idle_pct = 38;
      end
      if (p == 8) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      set_wall_count(plan[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ((p == 2 || p == 6) && i == PHASE_ITEMS / 2) drain_results();
        if ($urandom_range(99) < 70)
          random_query();
        else
          random_wall($urandom_range(MAX_WALLS - 1));
      end
    end

    drain_results();
    repeat (HOLD_OFF) @(negedge clk);
    if (fail_count == 0 && hits_pending == 0)
      $display("circle_wall_collision_check_top test passed");
    else
      $display("circle_wall_collision_check_top test failed");
    $finish;
  end

endmodule
